// ===== sv/positional_list_insert_remove_defines.svh =====
// Assertion macros for the positional list block
`ifndef POSITIONAL_LIST_INSERT_REMOVE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PLI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pli_pkg.sv =====
// Shared constants, codes and types of the positional list block
package pli_pkg;

    localparam int LIST_DEPTH  = 256;
    localparam int ELEM_W      = 32;
    localparam int IDX_W       = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int CMD_W       = 3;
    localparam int POS_W       = 9;
    localparam int ST_W        = 2;
    localparam int GROUP_SIZE  = 16;
    localparam int NUM_GROUPS  = LIST_DEPTH / GROUP_SIZE;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_AT    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [IDX_W-1:0]  at;
        logic [ELEM_W-1:0] data;
    } pli_ctl_t;

endpackage

// ===== sv/pli_cell.sv =====
// One list entry cell: holds a value and shifts with its neighbors
module pli_cell (
    input  logic                         aclk,
    input  pli_pkg::pli_ctl_t            ctl,
    input  logic [pli_pkg::IDX_W-1:0]    idx,
    input  logic [pli_pkg::ELEM_W-1:0]   left_val,
    input  logic [pli_pkg::ELEM_W-1:0]   right_val,
    output logic [pli_pkg::ELEM_W-1:0]   value,
    output logic [pli_pkg::ELEM_W-1:0]   tap
);
    import pli_pkg::*;

    logic [ELEM_W-1:0] value_reg;
    logic [ELEM_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.ins) begin
            if (idx > ctl.at) begin
                value_next = left_val;
            end else if (idx == ctl.at) begin
                value_next = ctl.data;
            end
        end else if (ctl.rem && (idx >= ctl.at)) begin
            value_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = (ctl.rem && (idx == ctl.at)) ? value_reg : '0;

endmodule

// ===== sv/pli_tap_tree.sv =====
// Registered two-level OR tree that collects the removed entry from the cells
module pli_tap_tree (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [pli_pkg::ELEM_W-1:0]   tap [pli_pkg::LIST_DEPTH],
    output logic [pli_pkg::ELEM_W-1:0]   merged
);
    import pli_pkg::*;

    logic [ELEM_W-1:0] group_reg  [NUM_GROUPS];
    logic [ELEM_W-1:0] group_next [NUM_GROUPS];

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                group_next[g] = group_next[g] | tap[g * GROUP_SIZE + k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    always_comb begin
        merged = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            merged = merged | group_reg[g];
        end
    end

endmodule

// ===== sv/positional_list_insert_remove.sv =====
// Positional list top level: command decode, count, cell row and result register.
// An accepted request waits in the stage register until the output is free, and no
// new request is taken meanwhile; the removed-entry OR tree over the cells is
// registered once between acceptance and the result register.
// Reset (aresetn low, synchronous) empties the list and drops pending results;
// cell contents are not cleared.
module positional_list_insert_remove (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pli_pkg::CMD_W-1:0]   s_command,
    input  logic [pli_pkg::POS_W-1:0]   s_position,
    input  logic [pli_pkg::ELEM_W-1:0]  s_new_element,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pli_pkg::ELEM_W-1:0]  m_removed_element,
    output logic [pli_pkg::ST_W-1:0]    m_status,
    output logic [pli_pkg::CNT_W-1:0]   m_count_after
);
    import pli_pkg::*;
    `include "positional_list_insert_remove_defines.svh"

    logic [CNT_W-1:0]  count_reg,        count_next;
    logic              stage_vld_reg,    stage_vld_next;
    logic [ST_W-1:0]   stage_status_reg, stage_status_next;
    logic              m_valid_reg,      m_valid_next;
    logic [ST_W-1:0]   m_status_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic [ELEM_W-1:0] m_elem_reg;

    logic              s_acc;
    logic              out_free;
    logic              move_out;
    logic              ins_ok;
    logic              rem_ok;
    logic [CNT_W-1:0]  at_w;
    logic [ST_W-1:0]   status;
    pli_ctl_t          ctl;
    logic [ELEM_W-1:0] merged;

    logic [ELEM_W-1:0] cell_val [LIST_DEPTH];
    logic [ELEM_W-1:0] cell_tap [LIST_DEPTH];

    assign s_ready  = !stage_vld_reg;
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign move_out = stage_vld_reg && out_free;

    always_comb begin
        at_w   = '0;
        status = ST_OK;
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        case (s_command)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                if (s_command == CMD_INS_BACK) begin
                    at_w = count_reg;
                end else if (s_command == CMD_INS_AT) begin
                    at_w = CNT_W'(s_position);
                end
                if (count_reg == CNT_W'(LIST_DEPTH)) begin
                    status = ST_FULL;
                end else if (at_w > count_reg) begin
                    status = ST_RANGE;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_AT: begin
                if (s_command == CMD_REM_BACK) begin
                    at_w = count_reg - 1'b1;
                end else if (s_command == CMD_REM_AT) begin
                    at_w = CNT_W'(s_position);
                end
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else if (at_w >= count_reg) begin
                    status = ST_RANGE;
                end else begin
                    rem_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ctl.ins  = s_acc && ins_ok;
        ctl.rem  = s_acc && rem_ok;
        ctl.at   = at_w[IDX_W-1:0];
        ctl.data = s_new_element;
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + 1'b1;
        end else if (ctl.rem) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        stage_vld_next    = stage_vld_reg;
        stage_status_next = stage_status_reg;
        if (s_acc) begin
            stage_vld_next    = 1'b1;
            stage_status_next = status;
        end else if (move_out) begin
            stage_vld_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (move_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            stage_vld_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            stage_vld_reg <= stage_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_status_reg <= stage_status_next;
        if (move_out) begin
            m_status_reg <= stage_status_reg;
            m_count_reg  <= count_reg;
            m_elem_reg   <= merged;
        end
    end

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic [ELEM_W-1:0] left_val;
        logic [ELEM_W-1:0] right_val;

        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[i+1];
        end

        pli_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .idx       (IDX_W'(i)),
            .left_val  (left_val),
            .right_val (right_val),
            .value     (cell_val[i]),
            .tap       (cell_tap[i])
        );
    end

    pli_tap_tree u_tap_tree (
        .aclk   (aclk),
        .load   (s_acc),
        .tap    (cell_tap),
        .merged (merged)
    );

    assign m_valid           = m_valid_reg;
    assign m_removed_element = m_elem_reg;
    assign m_status          = m_status_reg;
    assign m_count_after     = m_count_reg;

    `PLI_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(LIST_DEPTH), "count beyond depth")
    `PLI_ASSERT_NEXT(a_ins_count, ctl.ins, count_reg == CNT_W'($past(count_reg) + 1'b1), "insert count")
    `PLI_ASSERT_NEXT(a_rem_count, ctl.rem, count_reg == CNT_W'($past(count_reg) - 1'b1), "remove count")
    `PLI_ASSERT_NOW(a_fail_zero, m_valid && m_status != ST_OK, m_removed_element == '0, "failed nonzero")

endmodule
